>>> src/brew_process_sequencer_unit_assert.svh
// Assertion macros for the brew process sequencer
`ifndef BREW_PROCESS_SEQUENCER_UNIT_ASSERT_SVH
`define BREW_PROCESS_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bps assertion failed");

// next-cycle implication, disabled in reset
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bps assertion failed");

`endif

>>> src/bps_pkg.sv
// Types, state codes and valve table of the brew process sequencer
package bps_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASH_VOLUME         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARGE_BATCH_VOLUME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARGE_REST_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARGE_BATCH_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOIL_TICKS          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_MARGIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_MARGIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VOLUME        = 3'd7;

    // sequence states
    localparam logic [3:0] ST_INIT        = 4'd0;
    localparam logic [3:0] ST_WAIT_HLT    = 4'd1;
    localparam logic [3:0] ST_FILL        = 4'd2;
    localparam logic [3:0] ST_MASH        = 4'd3;
    localparam logic [3:0] ST_BYPASS      = 4'd4;
    localparam logic [3:0] ST_SPARGE_REST = 4'd5;
    localparam logic [3:0] ST_PUMP_OUT    = 4'd6;
    localparam logic [3:0] ST_PUMP_IN     = 4'd7;
    localparam logic [3:0] ST_DELAY       = 4'd8;
    localparam logic [3:0] ST_EMPTY_TUN   = 4'd9;
    localparam logic [3:0] ST_BOIL        = 4'd10;
    localparam logic [3:0] ST_EMPTY_HEX   = 4'd11;
    localparam logic [3:0] ST_CHILL       = 4'd12;

    localparam logic [1:0] FLAG_PID_ENABLE = 2'h1;
    localparam logic [1:0] FLAG_RESTART    = 2'h2;

    typedef struct packed {
        logic [15:0]        mlt_volume;
        logic signed [15:0] mlt_temp;
        logic signed [15:0] step_temp;
        logic               first_step_started;
        logic               mash_done;
        logic [1:0]         pid_flags;
        logic [15:0]        valves_in;
    } sample_t;

    typedef struct packed {
        logic [3:0]  seq_state;
        logic [15:0] valves_out;
    } result_t;

    function automatic logic [15:0] valve_bits(input logic [3:0] st);
        logic [15:0] v;
        case (st)
            ST_INIT:        v = 16'h0000;
            ST_WAIT_HLT:    v = 16'h0024;
            ST_FILL:        v = 16'h0015;
            ST_MASH:        v = 16'h0013;
            ST_BYPASS:      v = 16'h0023;
            ST_SPARGE_REST: v = 16'h0013;
            ST_PUMP_OUT:    v = 16'h0093;
            ST_PUMP_IN:     v = 16'h0017;
            ST_DELAY:       v = 16'h0013;
            ST_EMPTY_TUN:   v = 16'h0083;
            ST_BOIL:        v = 16'h0010;
            ST_EMPTY_HEX:   v = 16'h0013;
            ST_CHILL:       v = 16'h00c1;
            default:        v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

endpackage

>>> src/bps_stream_if.sv
// Valid/ready stream interface carrying one payload beat
interface bps_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/brew_process_sequencer_unit.sv
// Brew process sequencer: state stepping and valve word per sample tick
//
//  channel   dir  payload                                   handshake
//  sample    in   mlt_volume..valves_in (sample_t)          valid/ready
//  result    out  seq_state, valves_out (result_t)          valid/ready
//  cfg       in   cfg_index, cfg_data                       cfg_we, no wait
//
// One beat per cycle while the result is taken; two registers (input, result).
// The sequence state update is one pass of logic between the two registers.
// Reset puts the sequence in init and resets config and valid flags, not payloads.
// A stalled result holds both stages; the input stage still takes a beat while empty.
`include "brew_process_sequencer_unit_assert.svh"

module brew_process_sequencer_unit
    import bps_pkg::*;
#(
    parameter int ONE_SEC_TICKS   = 1,
    parameter int HEX_WAIT_TICKS  = 60,
    parameter int HEX_EMPTY_TICKS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bps_stream_if.sink            sample,
    bps_stream_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [15:0] ONE_SEC_LIM   = 16'(ONE_SEC_TICKS);
    localparam logic [15:0] HEX_WAIT_LIM  = 16'(HEX_WAIT_TICKS);
    localparam logic [15:0] HEX_EMPTY_LIM = 16'(HEX_EMPTY_TICKS);

    // configuration
    logic [15:0]        mash_volume_reg;
    logic [15:0]        sparge_batch_volume_reg;
    logic [15:0]        sparge_rest_ticks_reg;
    logic [7:0]         sparge_batch_count_reg;
    logic [15:0]        boil_ticks_reg;
    logic signed [13:0] temp_high_margin_reg;
    logic signed [13:0] temp_low_margin_reg;
    logic [15:0]        empty_volume_reg;

    // sequence state
    logic [3:0]  state_reg, state_next;
    logic [7:0]  sparge_index_reg, sparge_index_next;
    logic [15:0] rest_timer_reg, rest_timer_next;
    logic [15:0] delay_timer_reg, delay_timer_next;
    logic [15:0] hex_wait_timer_reg, hex_wait_timer_next;
    logic        hex_wait_disabled_reg, hex_wait_disabled_next;
    logic [15:0] hex_empty_timer_reg, hex_empty_timer_next;
    logic [15:0] boil_timer_reg, boil_timer_next;
    logic [15:0] mash_end_volume_reg, mash_end_volume_next;

    // pipeline
    logic    in_valid_reg;
    sample_t in_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    logic    fire;

    // datapath temporaries
    logic signed [17:0] temp_x;
    logic signed [17:0] hi_limit;
    logic signed [17:0] lo_limit;
    logic [16:0]        pump_sum;
    logic [8:0]         next_batch;
    logic [15:0]        rest_inc;
    logic [15:0]        delay_inc;
    logic [15:0]        boil_inc;
    logic [15:0]        hex_wait_inc;
    logic [15:0]        hex_empty_inc;
    logic [15:0]        override_mask;
    logic [15:0]        table_bits;

    assign advance      = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

    always_comb
    begin
        temp_x     = 18'(in_reg.mlt_temp);
        hi_limit   = 18'(in_reg.step_temp) + 18'(temp_high_margin_reg);
        lo_limit   = 18'(in_reg.step_temp) + 18'(temp_low_margin_reg);
        // vol < end - batch, kept unsigned
        pump_sum   = {1'b0, in_reg.mlt_volume} + {1'b0, sparge_batch_volume_reg};
        next_batch = {1'b0, sparge_index_reg} + 9'd1;
        rest_inc      = sat_inc16(rest_timer_reg);
        delay_inc     = sat_inc16(delay_timer_reg);
        boil_inc      = sat_inc16(boil_timer_reg);
        hex_wait_inc  = sat_inc16(hex_wait_timer_reg);
        hex_empty_inc = sat_inc16(hex_empty_timer_reg);

        state_next             = state_reg;
        sparge_index_next      = sparge_index_reg;
        rest_timer_next        = rest_timer_reg;
        delay_timer_next       = delay_timer_reg;
        hex_wait_timer_next    = hex_wait_timer_reg;
        hex_wait_disabled_next = hex_wait_disabled_reg;
        hex_empty_timer_next   = hex_empty_timer_reg;
        boil_timer_next        = boil_timer_reg;
        mash_end_volume_next   = mash_end_volume_reg;

        case (state_reg)
            ST_INIT:
                if ((in_reg.pid_flags & FLAG_PID_ENABLE) != 2'b00)
                    state_next = ST_WAIT_HLT;
            ST_WAIT_HLT:
                if (in_reg.first_step_started)
                    state_next = ST_FILL;
            ST_FILL:
                if (in_reg.mlt_volume > mash_volume_reg)
                    state_next = ST_MASH;
            ST_MASH:
            begin
                if (in_reg.mash_done)
                begin
                    sparge_index_next    = 8'd0;
                    mash_end_volume_next = in_reg.mlt_volume;
                    rest_timer_next      = sparge_rest_ticks_reg;
                    state_next           = ST_SPARGE_REST;
                end
                else if (temp_x > hi_limit)
                begin
                    state_next = ST_BYPASS;
                end
            end
            ST_BYPASS:
                if (temp_x < lo_limit)
                    state_next = ST_MASH;
            ST_SPARGE_REST:
            begin
                rest_timer_next = rest_inc;
                if (rest_inc >= sparge_rest_ticks_reg)
                    state_next = (next_batch < {1'b0, sparge_batch_count_reg}) ?
                                 ST_PUMP_OUT : ST_EMPTY_TUN;
            end
            ST_PUMP_OUT:
                if (pump_sum < {1'b0, mash_end_volume_reg})
                begin
                    delay_timer_next = 16'd0;
                    state_next       = ST_DELAY;
                end
            ST_PUMP_IN:
                if (in_reg.mlt_volume > mash_end_volume_reg)
                begin
                    if (sparge_index_reg != 8'hFF)
                        sparge_index_next = sparge_index_reg + 8'd1;
                    rest_timer_next = 16'd0;
                    state_next      = ST_SPARGE_REST;
                end
            ST_DELAY:
            begin
                delay_timer_next = delay_inc;
                if (delay_inc >= ONE_SEC_LIM)
                    state_next = ST_PUMP_IN;
            end
            ST_EMPTY_TUN:
                if (in_reg.mlt_volume < empty_volume_reg)
                begin
                    hex_wait_timer_next    = 16'd0;
                    hex_wait_disabled_next = 1'b0;
                    boil_timer_next        = 16'd0;
                    state_next             = ST_BOIL;
                end
            ST_BOIL:
            begin
                boil_timer_next = boil_inc;
                if (!hex_wait_disabled_reg)
                    hex_wait_timer_next = hex_wait_inc;
                if (!hex_wait_disabled_reg && hex_wait_inc >= HEX_WAIT_LIM)
                begin
                    hex_empty_timer_next = 16'd0;
                    state_next           = ST_EMPTY_HEX;
                end
                else if (boil_inc >= boil_ticks_reg)
                begin
                    state_next = ST_CHILL;
                end
            end
            ST_EMPTY_HEX:
            begin
                boil_timer_next      = boil_inc;
                hex_empty_timer_next = hex_empty_inc;
                if (hex_empty_inc >= HEX_EMPTY_LIM)
                begin
                    hex_wait_disabled_next = 1'b1;
                    state_next             = ST_BOIL;
                end
            end
            ST_CHILL:
                if ((in_reg.pid_flags & FLAG_RESTART) != 2'b00)
                    state_next = ST_INIT;
            default:
                state_next = ST_INIT;
        endcase

        // valves V1..V7 without manual override take the table bits
        override_mask = {8'h00, ~in_reg.valves_in[15:9], 1'b0};
        table_bits    = valve_bits(state_next);
        result_next.seq_state  = state_next;
        result_next.valves_out = (in_reg.valves_in & ~override_mask) |
                                 (table_bits & override_mask);
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg               <= ST_INIT;
            sparge_index_reg        <= 8'd0;
            rest_timer_reg          <= 16'd0;
            delay_timer_reg         <= 16'd0;
            hex_wait_timer_reg      <= 16'd0;
            hex_wait_disabled_reg   <= 1'b0;
            hex_empty_timer_reg     <= 16'd0;
            boil_timer_reg          <= 16'd0;
            mash_end_volume_reg     <= 16'd0;
            mash_volume_reg         <= 16'd0;
            sparge_batch_volume_reg <= 16'd0;
            sparge_rest_ticks_reg   <= 16'd0;
            sparge_batch_count_reg  <= 8'd1;
            boil_ticks_reg          <= 16'd0;
            temp_high_margin_reg    <= 14'sd0;
            temp_low_margin_reg     <= 14'sd0;
            empty_volume_reg        <= 16'd0;
        end
        else
        begin
            if (sample.ready)
                in_valid_reg <= sample.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                state_reg             <= state_next;
                sparge_index_reg      <= sparge_index_next;
                rest_timer_reg        <= rest_timer_next;
                delay_timer_reg       <= delay_timer_next;
                hex_wait_timer_reg    <= hex_wait_timer_next;
                hex_wait_disabled_reg <= hex_wait_disabled_next;
                hex_empty_timer_reg   <= hex_empty_timer_next;
                boil_timer_reg        <= boil_timer_next;
                mash_end_volume_reg   <= mash_end_volume_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MASH_VOLUME:         mash_volume_reg         <= cfg_data;
                    REG_SPARGE_BATCH_VOLUME: sparge_batch_volume_reg <= cfg_data;
                    REG_SPARGE_REST_TICKS:   sparge_rest_ticks_reg   <= cfg_data;
                    REG_SPARGE_BATCH_COUNT:  sparge_batch_count_reg  <= cfg_data[7:0];
                    REG_BOIL_TICKS:          boil_ticks_reg          <= cfg_data;
                    REG_TEMP_HIGH_MARGIN:    temp_high_margin_reg    <= cfg_data[13:0];
                    REG_TEMP_LOW_MARGIN:     temp_low_margin_reg     <= cfg_data[13:0];
                    REG_EMPTY_VOLUME:        empty_volume_reg        <= cfg_data;
                    default:                 empty_volume_reg        <= empty_volume_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
            in_reg <= sample.data;
        if (fire)
            result_reg <= result_next;
    end

    `BPS_ASSERT_NOW(a_result_tracks_state, clk, rst_n, out_valid_reg, result_reg.seq_state == state_reg)
    `BPS_ASSERT_NEXT(a_mash_done_to_rest, clk, rst_n, fire && state_reg == ST_MASH && in_reg.mash_done, state_reg == ST_SPARGE_REST)
    `BPS_ASSERT_NEXT(a_override_passes, clk, rst_n, fire, result_reg.valves_out[15:8] == $past(in_reg.valves_in[15:8]) && result_reg.valves_out[0] == $past(in_reg.valves_in[0]))

endmodule

>>> tb/brew_process_sequencer_unit_tb.sv
// Self-checking testbench for the brew process sequencer: steered brew runs against a tick model
`timescale 1ns / 100ps

module brew_process_sequencer_unit_tb;
    import bps_pkg::*;

    localparam int SEC_TICKS      = 1;
    localparam int HEX_WAIT       = 60;
    localparam int HEX_DRAIN      = 20;
    localparam int TEMP_MIN       = -5000;
    localparam int TEMP_MAX       = 20000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int QUIET_LIMIT    = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_TICKS    = 220;

    // valve pattern per state, chill first
    localparam logic [12:0][15:0] STAGE_VALVES = {
        16'h00c1, 16'h0013, 16'h0010, 16'h0083, 16'h0013, 16'h0017, 16'h0093,
        16'h0013, 16'h0023, 16'h0013, 16'h0015, 16'h0024, 16'h0000
    };

    typedef struct {
        logic [3:0]  st;
        logic [7:0]  batch_idx;
        logic [15:0] rest_t;
        logic [15:0] delay_t;
        logic [15:0] hex_wait_t;
        logic [15:0] hex_empty_t;
        logic [15:0] boil_t;
        logic [15:0] end_vol;
        bit          hex_off;
    } brew_ctx_t;

    typedef struct {
        logic [15:0] fill_vol;
        logic [15:0] batch_vol;
        logic [15:0] rest_ticks;
        logic [7:0]  batch_cnt;
        logic [15:0] boil_ticks;
        int          hi_margin;
        int          lo_margin;
        logic [15:0] empty_vol;
    } recipe_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bps_stream_if #(.T(sample_t)) sample_ch ();
    bps_stream_if #(.T(result_t)) result_ch ();

    brew_process_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sample_t   queued_samples[$];
    result_t   due_results[$];
    brew_ctx_t live_ctx;
    brew_ctx_t plan_ctx;
    recipe_t   recipe;

    int fail_count;
    int samples_taken;
    int samples_offered;
    int results_taken;
    int results_seen;
    int quiet_cycles;
    int send_gap;
    int recv_hold;
    bit steady_send;
    bit steady_recv;

    always #5 clk = ~clk;

    function automatic logic [15:0] sat_up(input logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // one sample tick: advance the sequence, then build the valve word
    function automatic result_t brew_tick(inout brew_ctx_t c, input sample_t x);
        result_t     r;
        int          temp;
        int          step;
        bit          hex_due;
        logic [15:0] tbl;
        logic [15:0] keep;
        temp = x.mlt_temp;
        step = x.step_temp;
        hex_due = 1'b0;
        case (c.st)
            ST_INIT:
                if ((x.pid_flags & FLAG_PID_ENABLE) != 0) c.st = ST_WAIT_HLT;
            ST_WAIT_HLT:
                if (x.first_step_started) c.st = ST_FILL;
            ST_FILL:
                if (x.mlt_volume > recipe.fill_vol) c.st = ST_MASH;
            ST_MASH:
                if (x.mash_done)
                begin
                    c.batch_idx = '0;
                    c.end_vol = x.mlt_volume;
                    c.rest_t = recipe.rest_ticks;
                    c.st = ST_SPARGE_REST;
                end
                else if (temp > step + recipe.hi_margin)
                begin
                    c.st = ST_BYPASS;
                end
            ST_BYPASS:
                if (temp < step + recipe.lo_margin) c.st = ST_MASH;
            ST_SPARGE_REST:
            begin
                c.rest_t = sat_up(c.rest_t);
                if (c.rest_t >= recipe.rest_ticks)
                    c.st = (int'(c.batch_idx) + 1 < int'(recipe.batch_cnt)) ?
                           ST_PUMP_OUT : ST_EMPTY_TUN;
            end
            ST_PUMP_OUT:
                if (int'(x.mlt_volume) < int'(c.end_vol) - int'(recipe.batch_vol))
                begin
                    c.delay_t = '0;
                    c.st = ST_DELAY;
                end
            ST_PUMP_IN:
                if (x.mlt_volume > c.end_vol)
                begin
                    if (c.batch_idx != 8'hFF) c.batch_idx = c.batch_idx + 8'd1;
                    c.rest_t = '0;
                    c.st = ST_SPARGE_REST;
                end
            ST_DELAY:
            begin
                c.delay_t = sat_up(c.delay_t);
                if (int'(c.delay_t) >= SEC_TICKS) c.st = ST_PUMP_IN;
            end
            ST_EMPTY_TUN:
                if (x.mlt_volume < recipe.empty_vol)
                begin
                    c.hex_wait_t = '0;
                    c.hex_off = 1'b0;
                    c.boil_t = '0;
                    c.st = ST_BOIL;
                end
            ST_BOIL:
            begin
                c.boil_t = sat_up(c.boil_t);
                if (!c.hex_off)
                begin
                    c.hex_wait_t = sat_up(c.hex_wait_t);
                    hex_due = int'(c.hex_wait_t) >= HEX_WAIT;
                end
                if (hex_due)
                begin
                    c.hex_empty_t = '0;
                    c.st = ST_EMPTY_HEX;
                end
                else if (c.boil_t >= recipe.boil_ticks)
                begin
                    c.st = ST_CHILL;
                end
            end
            ST_EMPTY_HEX:
            begin
                c.boil_t = sat_up(c.boil_t);
                c.hex_empty_t = sat_up(c.hex_empty_t);
                if (int'(c.hex_empty_t) >= HEX_DRAIN)
                begin
                    c.hex_off = 1'b1;
                    c.st = ST_BOIL;
                end
            end
            ST_CHILL:
                if ((x.pid_flags & FLAG_RESTART) != 0) c.st = ST_INIT;
            default:
                c.st = ST_INIT;
        endcase
        tbl = (c.st <= ST_CHILL) ? STAGE_VALVES[c.st] : 16'h0000;
        keep = '0;
        for (int k = 1; k <= 7; k++)
            if (!x.valves_in[k + 8]) keep[k] = 1'b1;
        r.seq_state = c.st;
        r.valves_out = (x.valves_in & ~keep) | (tbl & keep);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int clamp_temp(input int v);
        return (v < TEMP_MIN) ? TEMP_MIN : ((v > TEMP_MAX) ? TEMP_MAX : v);
    endfunction

    function automatic logic [15:0] rand_temp();
        return 16'(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
    endfunction

    // a few counts either side of a threshold, so equality gets hit
    function automatic logic [15:0] near_temp(input int tgt);
        return 16'(clamp_temp(clamp_temp(tgt) + int'($urandom_range(0, 6)) - 3));
    endfunction

    function automatic logic [15:0] vol_over(input logic [15:0] th);
        if (th == 16'hFFFF) return th;
        if ($urandom_range(0, 1) == 0) return th + 16'd1;
        return 16'($urandom_range(int'(th) + 1, 65535));
    endfunction

    function automatic logic [15:0] vol_upto(input logic [15:0] th);
        if ($urandom_range(0, 1) == 0) return th;
        return 16'($urandom_range(0, int'(th)));
    endfunction

    function automatic logic [15:0] vol_under(input int th);
        if (th <= 0) return 16'h0000;
        if ($urandom_range(0, 1) == 0) return 16'(th - 1);
        return 16'($urandom_range(0, th - 1));
    endfunction

    // random tick, mostly steered so that the current state moves on now and then
    function automatic sample_t plan_sample(input brew_ctx_t c);
        sample_t x;
        bit      go;
        int      lim;
        x.mlt_volume = 16'($urandom_range(0, 65535));
        x.mlt_temp = rand_temp();
        x.step_temp = rand_temp();
        x.first_step_started = 1'($urandom_range(0, 1));
        x.mash_done = 1'($urandom_range(0, 1));
        x.pid_flags = 2'($urandom_range(0, 3));
        x.valves_in = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 15) return x;
        go = ($urandom_range(0, 2) == 0);
        x.mash_done = ($urandom_range(0, 15) == 0);
        case (c.st)
            ST_INIT:      x.pid_flags[0] = go;
            ST_WAIT_HLT:  x.first_step_started = go;
            ST_FILL:      x.mlt_volume = go ? vol_over(recipe.fill_vol) : vol_upto(recipe.fill_vol);
            ST_MASH:
            begin
                x.mash_done = ($urandom_range(0, 7) == 0);
                x.mlt_volume = 16'($urandom_range(0, 60000));
                x.mlt_temp = near_temp(int'(x.step_temp) + recipe.hi_margin);
            end
            ST_BYPASS:    x.mlt_temp = near_temp(int'(x.step_temp) + recipe.lo_margin);
            ST_PUMP_OUT:
            begin
                lim = int'(c.end_vol) - int'(recipe.batch_vol);
                if (go && lim > 0)
                    x.mlt_volume = vol_under(lim);
                else if (lim > 0)
                    x.mlt_volume = 16'($urandom_range(lim, 65535));
            end
            ST_PUMP_IN:   x.mlt_volume = go ? vol_over(c.end_vol) : vol_upto(c.end_vol);
            ST_EMPTY_TUN:
                if (go && recipe.empty_vol != 0)
                    x.mlt_volume = vol_under(int'(recipe.empty_vol));
                else
                    x.mlt_volume = 16'($urandom_range(int'(recipe.empty_vol), 65535));
            ST_CHILL:     x.pid_flags[1] = go;
            default:      ;
        endcase
        return x;
    endfunction

    function automatic sample_t tick_of(input logic [15:0] vol, input int temp, input int step,
                                        input bit started, input bit done,
                                        input logic [1:0] flags, input logic [15:0] valves);
        sample_t x;
        x.mlt_volume = vol;
        x.mlt_temp = temp[15:0];
        x.step_temp = step[15:0];
        x.first_step_started = started;
        x.mash_done = done;
        x.pid_flags = flags;
        x.valves_in = valves;
        return x;
    endfunction

    // the planning copy follows the queue so steering sees the state each tick will meet
    task automatic push_tick(input sample_t x);
        void'(brew_tick(plan_ctx, x));
        queued_samples.push_back(x);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic load_recipe(input recipe_t r);
        recipe = r;
        write_reg(REG_MASH_VOLUME, r.fill_vol);
        write_reg(REG_SPARGE_BATCH_VOLUME, r.batch_vol);
        write_reg(REG_SPARGE_REST_TICKS, r.rest_ticks);
        write_reg(REG_SPARGE_BATCH_COUNT, {8'h00, r.batch_cnt});
        write_reg(REG_BOIL_TICKS, r.boil_ticks);
        write_reg(REG_TEMP_HIGH_MARGIN, r.hi_margin[15:0]);
        write_reg(REG_TEMP_LOW_MARGIN, r.lo_margin[15:0]);
        write_reg(REG_EMPTY_VOLUME, r.empty_vol);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic recipe_t rand_recipe();
        recipe_t r;
        r.fill_vol = 16'($urandom_range(0, 3000));
        r.batch_vol = 16'($urandom_range(0, 400));
        r.rest_ticks = 16'($urandom_range(0, 5));
        r.batch_cnt = 8'($urandom_range(0, 4));
        r.boil_ticks = 16'($urandom_range(0, 120));
        r.hi_margin = int'($urandom_range(0, 400)) - 200;
        r.lo_margin = int'($urandom_range(0, 400)) - 200;
        r.empty_vol = 16'($urandom_range(0, 2000));
        return r;
    endfunction

    // offered count moves with the pop, so a beat being put up this edge is never missed
    task automatic drain();
        while (queued_samples.size() != 0 || samples_offered != samples_taken ||
               due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk)
    begin
        if (rst_n && !(sample_ch.valid && samples_offered != samples_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                sample_ch.valid <= 1'b0;
            end
            else if (queued_samples.size() != 0)
            begin
                sample_ch.data <= queued_samples.pop_front();
                sample_ch.valid <= 1'b1;
                samples_offered++;
                if ($urandom_range(0, 49) == 0) steady_send = !steady_send;
                send_gap = steady_send ? 0 : $urandom_range(0, 9);
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: short random stalls, now and then a long hold that backs the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_taken != results_seen)
            begin
                results_seen = results_taken;
                if ($urandom_range(0, 49) == 0) steady_recv = !steady_recv;
                if (results_seen % 400 == 200)
                    recv_hold = LONG_HOLD;
                else
                    recv_hold = steady_recv ? 0 : $urandom_range(0, 9);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : watch_ports
        result_t want;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (sample_ch.valid && sample_ch.ready)
            begin
                due_results.push_back(brew_tick(live_ctx, sample_ch.data));
                samples_taken++;
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_taken++;
                moved = 1'b1;
                if (due_results.size() == 0)
                begin
                    note_mismatch("beat with nothing due", int'(result_ch.data), 0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_ch.data.seq_state != want.seq_state)
                        note_mismatch("seq_state", int'(result_ch.data.seq_state),
                                      int'(want.seq_state));
                    if (result_ch.data.valves_out != want.valves_out)
                        note_mismatch("valves_out", int'(result_ch.data.valves_out),
                                      int'(want.valves_out));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no beat for %0d cycles", $time, quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run_brews
        recipe_t r;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        result_ch.ready = 1'b0;
        live_ctx = '{default: '0};
        plan_ctx = '{default: '0};
        recipe = '{default: '0};
        recipe.batch_cnt = 8'd1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk through a whole brew, thresholds hit exactly
        r = '{fill_vol: 16'd100, batch_vol: 16'd50, rest_ticks: 16'd2, batch_cnt: 8'd2,
              boil_ticks: 16'd3, hi_margin: 50, lo_margin: -20, empty_vol: 16'd10};
        load_recipe(r);
        push_tick(tick_of(16'd0, 2000, 6500, 1'b0, 1'b0, 2'b00, 16'h0000));
        push_tick(tick_of(16'd0, 2000, 6500, 1'b0, 1'b0, FLAG_PID_ENABLE, 16'hFFFF));
        push_tick(tick_of(16'd50, 2000, 6500, 1'b1, 1'b0, FLAG_PID_ENABLE, 16'hFE00));
        push_tick(tick_of(16'd100, 6500, 6500, 1'b0, 1'b0, FLAG_PID_ENABLE, 16'h01FF));
        push_tick(tick_of(16'd101, 6550, 6500, 1'b0, 1'b0, FLAG_PID_ENABLE, 16'hAAAA));
        push_tick(tick_of(16'd500, 6550, 6500, 1'b1, 1'b0, FLAG_PID_ENABLE, 16'h5555));
        push_tick(tick_of(16'd500, 6551, 6500, 1'b1, 1'b0, 2'b00, 16'h00FF));
        push_tick(tick_of(16'd500, 6480, 6500, 1'b1, 1'b0, 2'b00, 16'hFF00));
        push_tick(tick_of(16'd500, 6479, 6500, 1'b1, 1'b0, 2'b00, 16'h0F0F));
        push_tick(tick_of(16'd500, 6500, 6500, 1'b1, 1'b1, 2'b00, 16'hF0F0));
        push_tick(tick_of(16'd500, 6500, 6500, 1'b1, 1'b1, 2'b11,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd450, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd449, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd449, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd500, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd501, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd501, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd501, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd10, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd9, 6500, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd9, 9900, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd9, 9900, 6500, 1'b0, 1'b0, 2'b00,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'd9, 9900, 6500, 1'b0, 1'b0, FLAG_PID_ENABLE,
                          16'($urandom_range(0, 65535))));
        push_tick(tick_of(16'hFFFF, TEMP_MAX, TEMP_MIN, 1'b1, 1'b1, 2'b01, 16'hFFFF));
        push_tick(tick_of(16'd0, TEMP_MIN, TEMP_MAX, 1'b0, 1'b0, FLAG_RESTART, 16'h0000));
        drain();

        // unreachable pump-out threshold, zero batch count, opposite margin extremes
        r = '{fill_vol: 16'd0, batch_vol: 16'hFFFF, rest_ticks: 16'd0, batch_cnt: 8'd0,
              boil_ticks: 16'd0, hi_margin: 5000, lo_margin: -5000, empty_vol: 16'hFFFF};
        load_recipe(r);
        repeat (150) push_tick(plan_sample(plan_ctx));
        drain();

        // rest timer starts saturated; fill cannot end
        r = '{fill_vol: 16'hFFFF, batch_vol: 16'd0, rest_ticks: 16'hFFFF, batch_cnt: 8'hFF,
              boil_ticks: 16'hFFFF, hi_margin: -5000, lo_margin: 5000, empty_vol: 16'd0};
        load_recipe(r);
        repeat (60) push_tick(plan_sample(plan_ctx));
        drain();

        repeat (RANDOM_PHASES)
        begin
            load_recipe(rand_recipe());
            repeat (PHASE_TICKS) push_tick(plan_sample(plan_ctx));
            drain();
        end

        if (due_results.size() != 0)
            note_mismatch("results never delivered", 0, due_results.size());
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
